[rtl/idwm_pkg.sv]
// Shared types and constants for the IMU dual-window mean block.
// No dependencies; every other file of the block but idwm_ram refers to this package by scoped names.
package idwm_pkg;

  // Sample format and channel count fixed by the stream layout.
  localparam int SAMPLE_BITS = 16;
  localparam int CHANNELS    = 6;
  localparam int MEANS       = 2 * CHANNELS;
  localparam int IDX_W       = $clog2(MEANS);
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration register.
  localparam int                  RATIO_W     = 7;
  localparam logic [RATIO_W-1:0]  RATIO_RESET = 7'd50;
  localparam int                  MIN_RATIO   = 2;
  localparam int                  APB_DW      = 32;
  localparam int                  APB_AW      = 3;
  localparam logic [APB_AW-1:0]   ADDR_RATIO  = 3'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             clear_init;
    logic             clear_wr;
    logic             load;
    logic             update;
    logic             mul;
    logic             store;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } idwm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } idwm_sts_t;

endpackage

[rtl/imu_dual_window_mean_top.sv]
// Top level of the IMU dual-window mean block: stream ports, APB register, controller
// and datapath. Depends on idwm_pkg, idwm_ctrl, idwm_dp and idwm_ram.
//
// Each valid six-channel IMU word enters a recent window of camera_ratio/2 samples; the sample
// it displaces enters an older window of camera_ratio samples, and one output word carries the
// truncated means of every channel over both windows (camera_ratio clamped to MIN_RATIO through
// MAX_RATIO). Words flagged invalid are dropped. The ring read happens at the accepting edge;
// then come the window update, a multiply and a store step for each of the twelve means, which
// share one reciprocal multiplier, and the load of the output register. The next word is taken
// only after that load, which waits while the previous output word is still waiting. After
// reset and after every write of camera_ratio, a clearing pass zeroes every entry of both
// rings, during which no input word is taken.
module imu_dual_window_mean_top #(
  parameter int MAX_RATIO = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z (16 bits each, from bit 0)
  input  logic [95:0]                   s_tdata,
  // sample_invalid
  input  logic                          s_tuser,
  // Output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // recent_rate_x..z, recent_accel_x..z, older_rate_x..z, older_accel_x..z (16 bits each)
  output logic [191:0]                  m_tdata,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [idwm_pkg::APB_AW-1:0]   paddr,
  input  logic [idwm_pkg::APB_DW-1:0]   pwdata,
  output logic [idwm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  logic [idwm_pkg::RATIO_W-1:0] camera_ratio;
  logic                         cfg_wr;
  idwm_pkg::idwm_cmd_t          cmd;
  idwm_pkg::idwm_sts_t          sts;

  // Register access.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == idwm_pkg::ADDR_RATIO);
  assign prdata = (paddr == idwm_pkg::ADDR_RATIO) ?
                  idwm_pkg::APB_DW'(camera_ratio) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_ratio <= idwm_pkg::RATIO_RESET;
    end else if (cfg_wr) begin
      camera_ratio <= pwdata[idwm_pkg::RATIO_W-1:0];
    end
  end

  idwm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .in_valid   (s_tvalid),
    .in_invalid (s_tuser),
    .in_ready   (s_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  idwm_dp #(.MAX_RATIO(MAX_RATIO)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .camera_ratio (camera_ratio),
    .sample_data  (s_tdata),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_data     (m_tdata)
  );

endmodule

[rtl/idwm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module idwm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/idwm_ctrl.sv]
// Controller of the IMU dual-window mean block: clearing pass, item sequencing, output hand-off.
// Depends on idwm_pkg.
module idwm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic                  in_valid,
  input  logic                  in_invalid,
  output logic                  in_ready,
  output idwm_pkg::idwm_cmd_t   cmd,
  input  idwm_pkg::idwm_sts_t   sts
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_STO  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [idwm_pkg::IDX_W-1:0] IDX_LAST = idwm_pkg::IDX_W'(idwm_pkg::MEANS - 1);

  logic [2:0]                   state, state_next;
  logic [idwm_pkg::IDX_W-1:0]   idx, idx_next;
  logic                         load;

  assign in_ready = (state == S_IDLE);
  assign load     = in_valid && in_ready && !in_invalid;

  // Next state and mean index.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      S_CLR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (load) state_next = S_UPD;
      end
      S_UPD: begin
        idx_next   = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_STO;
      end
      S_STO: begin
        if (idx == IDX_LAST) begin
          state_next = S_DONE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_MUL;
        end
      end
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLR;
    endcase
    // A register write restarts the clearing pass.
    if (cfg_wr) state_next = S_CLR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd            = '0;
    cmd.clear_init = cfg_wr;
    cmd.clear_wr   = (state == S_CLR) && !cfg_wr;
    cmd.load       = load;
    cmd.update     = (state == S_UPD);
    cmd.mul        = (state == S_MUL);
    cmd.store      = (state == S_STO);
    cmd.out_load   = (state == S_DONE) && sts.out_free;
    cmd.idx        = idx;
  end

  // A register write always sends the block back into its clearing pass.
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> state == S_CLR)
    else $error("register write did not start a clearing pass");

  // An accepted valid word goes straight to the window update.
  a_load_upd: assert property (@(posedge clk) disable iff (rst)
    (load && !cfg_wr) |=> state == S_UPD)
    else $error("accepted word not followed by window update");

  // The mean sequence steps through every index in order.
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_STO && idx != IDX_LAST && !cfg_wr) |=>
      (state == S_MUL && idx == $past(idx) + 1'b1))
    else $error("mean index skipped");

endmodule

[rtl/idwm_dp.sv]
// Datapath of the IMU dual-window mean block: sample rings, running sums, reciprocal
// divider and output register. Depends on idwm_pkg and idwm_ram.
module idwm_dp #(
  parameter int MAX_RATIO = 64
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  idwm_pkg::idwm_cmd_t                                 cmd,
  output idwm_pkg::idwm_sts_t                                 sts,
  input  logic [idwm_pkg::RATIO_W-1:0]                        camera_ratio,
  input  logic [idwm_pkg::CHANNELS*idwm_pkg::SAMPLE_BITS-1:0] sample_data,
  input  logic                                                out_ready,
  output logic                                                out_valid,
  output logic [idwm_pkg::MEANS*idwm_pkg::SAMPLE_BITS-1:0]    out_data
);

  localparam int SB     = idwm_pkg::SAMPLE_BITS;
  localparam int CH     = idwm_pkg::CHANNELS;
  localparam int ROW_W  = CH * SB;
  localparam int RDEPTH = MAX_RATIO / 2;
  localparam int OA_W   = (MAX_RATIO > 1) ? $clog2(MAX_RATIO) : 1;
  localparam int RA_W   = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int LEN_W  = $clog2(MAX_RATIO + 1);
  localparam int SUM_W  = SB + $clog2(MAX_RATIO);
  localparam int K      = SUM_W - 1 + $clog2(MAX_RATIO);
  localparam int M_W    = K + 1;
  localparam int P_W    = SUM_W + M_W;

  logic [LEN_W-1:0] olen, rlen;
  logic [RA_W-1:0]  rp, rp_eff, rp_inc;
  logic [OA_W-1:0]  op, op_eff, op_inc;
  logic [OA_W-1:0]  clr_addr;
  logic [ROW_W-1:0] sample_reg;
  logic [ROW_W-1:0] r_rdata, o_rdata, r_wdata, o_wdata;
  logic [RA_W-1:0]  r_waddr;
  logic [OA_W-1:0]  o_waddr;
  logic             r_we, o_we;

  logic signed [SB-1:0]    fresh [CH];
  logic signed [SB-1:0]    moved [CH];
  logic signed [SB-1:0]    dropped [CH];
  logic signed [SUM_W-1:0] rsum [CH];
  logic signed [SUM_W-1:0] osum [CH];

  logic [M_W-1:0]          recip_tab [MAX_RATIO+1];
  logic [idwm_pkg::CH_W-1:0] ch;
  logic signed [SUM_W-1:0] sel_sum;
  logic [SUM_W-1:0]        mag;
  logic [LEN_W-1:0]        div;
  logic [P_W-1:0]          prod;
  logic                    neg;
  logic [P_W-K-1:0]        quo, quo_s;
  logic [SB-1:0]           res [idwm_pkg::MEANS];

  // Window lengths from the register, clamped to the supported range.
  always_comb begin
    if (int'(camera_ratio) < idwm_pkg::MIN_RATIO) begin
      olen = LEN_W'(idwm_pkg::MIN_RATIO);
    end else if (int'(camera_ratio) > MAX_RATIO) begin
      olen = LEN_W'(MAX_RATIO);
    end else begin
      olen = LEN_W'(camera_ratio);
    end
    rlen = olen >> 1;
  end

  // Ring positions, each wrapping at its own length.
  always_comb begin
    rp_eff = (int'(rp) >= int'(rlen)) ? '0 : rp;
    op_eff = (int'(op) >= int'(olen)) ? '0 : op;
    rp_inc = (int'(rp_eff) + 1 >= int'(rlen)) ? '0 : rp_eff + RA_W'(1);
    op_inc = (int'(op_eff) + 1 >= int'(olen)) ? '0 : op_eff + OA_W'(1);
  end

  // RAM write ports: clearing pass or window update.
  always_comb begin
    r_we    = (cmd.clear_wr && int'(clr_addr) < RDEPTH) || cmd.update;
    o_we    = cmd.clear_wr || cmd.update;
    r_waddr = cmd.clear_wr ? RA_W'(clr_addr) : rp_eff;
    o_waddr = cmd.clear_wr ? clr_addr : op_eff;
    r_wdata = cmd.clear_wr ? '0 : sample_reg;
    o_wdata = cmd.clear_wr ? '0 : r_rdata;
  end

  idwm_ram #(.WIDTH(ROW_W), .DEPTH(RDEPTH)) u_recent (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .re    (cmd.load),
    .raddr (rp_eff),
    .rdata (r_rdata)
  );

  idwm_ram #(.WIDTH(ROW_W), .DEPTH(MAX_RATIO)) u_older (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .re    (cmd.load),
    .raddr (op_eff),
    .rdata (o_rdata)
  );

  // Split rows into channels.
  always_comb begin
    for (int c = 0; c < CH; c++) begin
      fresh[c]   = sample_reg[c*SB +: SB];
      moved[c]   = r_rdata[c*SB +: SB];
      dropped[c] = o_rdata[c*SB +: SB];
    end
  end

  // Clear counter, positions and running sums.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_init) begin
      clr_addr <= '0;
      rp       <= '0;
      op       <= '0;
      for (int c = 0; c < CH; c++) begin
        rsum[c] <= '0;
        osum[c] <= '0;
      end
    end else begin
      if (cmd.clear_wr) begin
        clr_addr <= clr_addr + OA_W'(1);
      end
      if (cmd.update) begin
        rp <= rp_inc;
        op <= op_inc;
        for (int c = 0; c < CH; c++) begin
          rsum[c] <= rsum[c] + SUM_W'(fresh[c]) - SUM_W'(moved[c]);
          osum[c] <= osum[c] + SUM_W'(moved[c]) - SUM_W'(dropped[c]);
        end
      end
    end
  end

  assign sts.clear_last = cmd.clear_wr && (int'(clr_addr) == MAX_RATIO - 1);
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_reg <= sample_data;
    end
  end

  // Reciprocal table: ceil(2^K / n), exact for every sum magnitude.
  assign recip_tab[0] = '0;
  for (genvar n = 1; n <= MAX_RATIO; n++) begin : g_recip
    localparam longint unsigned RV = ((64'd1 << K) + n - 1) / n;
    assign recip_tab[n] = M_W'(RV);
  end

  // Select one running sum and its window length.
  always_comb begin
    if (cmd.idx < idwm_pkg::IDX_W'(CH)) begin
      ch      = idwm_pkg::CH_W'(cmd.idx);
      sel_sum = rsum[ch];
      div     = rlen;
    end else begin
      ch      = idwm_pkg::CH_W'(cmd.idx - idwm_pkg::IDX_W'(CH));
      sel_sum = osum[ch];
      div     = olen;
    end
    mag = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : sel_sum;
  end

  // Multiply by the reciprocal, then scale and restore the sign.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= mag * recip_tab[div];
      neg  <= sel_sum[SUM_W-1];
    end
  end

  assign quo   = prod[P_W-1:K];
  assign quo_s = neg ? -quo : quo;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      res[cmd.idx] <= SB'(quo_s);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < idwm_pkg::MEANS; i++) begin
        out_data[i*SB +: SB] <= res[i];
      end
    end
  end

  // A new output word only ever comes from a load command.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output word appeared without a load");

endmodule

[tb/idwm_checker.sv]
// Checker for the IMU dual-window mean block: watches both streams and the APB port,
// predicts each output word and compares it field by field. Depends on idwm_pkg.
module idwm_checker #(
  parameter int MAX_RATIO = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [95:0]                 s_tdata,
  input  logic                        s_tuser,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [191:0]                m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [idwm_pkg::APB_AW-1:0] paddr,
  input  logic [idwm_pkg::APB_DW-1:0] pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          means_pending
);

  localparam int RECENT_MAX = MAX_RATIO / 2;

  logic signed [idwm_pkg::SAMPLE_BITS-1:0] recent_ring [RECENT_MAX][idwm_pkg::CHANNELS];
  logic signed [idwm_pkg::SAMPLE_BITS-1:0] older_ring [MAX_RATIO][idwm_pkg::CHANNELS];
  logic signed [31:0]            recent_total [idwm_pkg::CHANNELS];
  logic signed [31:0]            older_total [idwm_pkg::CHANNELS];
  int                            recent_wr;
  int                            older_wr;
  logic [idwm_pkg::RATIO_W-1:0]  ratio_reg;
  logic [191:0]                  mean_words [$];

  task automatic report(input string what, input int field, input logic [15:0] got,
                        input logic [15:0] want);
    $display("mismatch: %s field %0d got %h want %h at %0t", what, field, got, want, $time);
    fail_count++;
  endtask

  function automatic void clear_windows();
    for (int i = 0; i < RECENT_MAX; i++)
      for (int c = 0; c < idwm_pkg::CHANNELS; c++) recent_ring[i][c] = '0;
    for (int i = 0; i < MAX_RATIO; i++)
      for (int c = 0; c < idwm_pkg::CHANNELS; c++) older_ring[i][c] = '0;
    for (int c = 0; c < idwm_pkg::CHANNELS; c++) begin
      recent_total[c] = 0;
      older_total[c]  = 0;
    end
    recent_wr = 0;
    older_wr  = 0;
  endfunction

  // Push one valid sample through both rings and queue the resulting means.
  function automatic void take_sample(input logic [95:0] word);
    int olen;
    int rlen;
    logic signed [idwm_pkg::SAMPLE_BITS-1:0] fresh;
    logic signed [idwm_pkg::SAMPLE_BITS-1:0] moved;
    logic signed [idwm_pkg::SAMPLE_BITS-1:0] dropped;
    logic signed [31:0] q;
    logic [191:0] means;
    olen = (ratio_reg < idwm_pkg::MIN_RATIO) ? idwm_pkg::MIN_RATIO :
           (ratio_reg > MAX_RATIO) ? MAX_RATIO : int'(ratio_reg);
    rlen = olen / 2;
    if (recent_wr >= rlen) recent_wr = 0;
    if (older_wr >= olen) older_wr = 0;
    for (int c = 0; c < idwm_pkg::CHANNELS; c++) begin
      fresh   = word[c*16 +: 16];
      moved   = recent_ring[recent_wr][c];
      dropped = older_ring[older_wr][c];
      older_ring[older_wr][c]   = moved;
      recent_ring[recent_wr][c] = fresh;
      recent_total[c] += fresh - moved;
      older_total[c]  += moved - dropped;
    end
    recent_wr = (recent_wr + 1) % rlen;
    older_wr  = (older_wr + 1) % olen;
    // SystemVerilog signed division truncates toward zero, as required.
    for (int c = 0; c < idwm_pkg::CHANNELS; c++) begin
      q = recent_total[c] / rlen;
      means[c*16 +: 16] = q[15:0];
      q = older_total[c] / olen;
      means[(idwm_pkg::CHANNELS+c)*16 +: 16] = q[15:0];
    end
    mean_words.push_back(means);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ratio_reg = idwm_pkg::RATIO_RESET;
      clear_windows();
      mean_words.delete();
      fail_count = 0;
    end else begin
      // Register writes clear both windows.
      if (psel && penable && pwrite && pready && paddr == idwm_pkg::ADDR_RATIO) begin
        ratio_reg = pwdata[idwm_pkg::RATIO_W-1:0];
        clear_windows();
      end
      if (s_tvalid && s_tready && !s_tuser) take_sample(s_tdata);
      if (m_tvalid && m_tready) begin
        if (mean_words.size() == 0) begin
          report("unexpected word", 0, m_tdata[15:0], 16'h0);
        end else begin
          logic [191:0] want;
          want = mean_words.pop_front();
          for (int f = 0; f < idwm_pkg::MEANS; f++)
            if (m_tdata[f*16 +: 16] !== want[f*16 +: 16])
              report("mean", f, m_tdata[f*16 +: 16], want[f*16 +: 16]);
        end
      end
    end
    means_pending = mean_words.size();
  end
endmodule

[tb/testbench.sv]
// Stimulus and verdict for the IMU dual-window mean block: sends directed and random
// samples in bursts over several ratio settings. Depends on idwm_pkg, the block and idwm_checker.
module testbench;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z (16 bits each, from bit 0)
  logic [95:0] s_tdata;
  // sample_invalid
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  // recent means x..z rates, accels, then older means (16 bits each, from bit 0)
  logic [191:0] m_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [idwm_pkg::APB_AW-1:0] paddr;
  logic [idwm_pkg::APB_DW-1:0] pwdata;
  logic [idwm_pkg::APB_DW-1:0] prdata;
  logic pready;
  int fail_count;
  int means_pending;
  int cycle_count;
  bit stall_on;

  imu_dual_window_mean_top dut (.*);

  idwm_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit: well above the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stall pattern: long stretches of always-ready, others with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
    end else begin
      if (cycle_count % 2000 == 0) stall_on <= ~stall_on;
      m_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  task automatic write_ratio(input logic [idwm_pkg::APB_DW-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= idwm_pkg::ADDR_RATIO;
    pwdata  <= value;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Send one word and wait for it to be taken.
  task automatic send_sample(input logic [95:0] data, input logic invalid);
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= invalid;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic pause_sender();
    s_tvalid <= 1'b0;
    repeat ($urandom_range(1, 40)) @(posedge clk);
  endtask

  function automatic logic [95:0] random_sample();
    logic [95:0] d;
    int pick;
    for (int c = 0; c < idwm_pkg::CHANNELS; c++) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: d[c*16 +: 16] = 16'h7fff;
        1: d[c*16 +: 16] = 16'h8000;
        default: d[c*16 +: 16] = 16'($urandom());
      endcase
    end
    return d;
  endfunction

  // Random bursts of samples, some invalid.
  task automatic random_phase(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_sample(random_sample(), $urandom_range(0, 9) == 0);
        left--;
      end
      pause_sender();
    end
    s_tvalid <= 1'b0;
  endtask

  // Wait for all means to arrive, then let the pipeline settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (means_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    logic [idwm_pkg::APB_DW-1:0] ratios [7];
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, an invalid word and a full-positive then full-negative run.
    send_sample({6{16'h7fff}}, 1'b0);
    send_sample({6{16'h8000}}, 1'b0);
    send_sample({6{16'h1234}}, 1'b1);
    send_sample(96'h0, 1'b0);
    send_sample({6{16'hffff}}, 1'b0);
    for (int i = 0; i < 12; i++) send_sample({6{16'h7fff}}, 1'b0);
    for (int i = 0; i < 6; i++) send_sample({6{16'h8001}}, 1'b0);
    drain();

    // Ratio 1 and 0 act as 2; above the maximum acts as the maximum; 127 sets every bit.
    ratios = '{32'd2, 32'd0, 32'd1, 32'd3, 32'd64, 32'd127, 32'd17};
    foreach (ratios[k]) begin
      write_ratio(ratios[k]);
      random_phase(210);
      drain();
    end
    // A write to an unused address is ignored.
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd4; pwdata <= 32'd5; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    random_phase(60);
    drain();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
